// File: rtl/tmh_pkg.sv
package tmh_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int BYTE_W        = 8;
    localparam int HASH_W        = 32;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_HASH = 1'b1;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // one mixing step: (h + m) * 1025, then xor with itself shifted right by 6
    function automatic hash_t mix_byte(input hash_t h, input byte_t m);
        hash_t s;
        hash_t t;
        s = h + {{(HASH_W-BYTE_W){1'b0}}, m};
        t = s + (s << 10);
        return t ^ (t >> 6);
    endfunction

    // first finishing step: times 9, then xor with itself shifted right by 11
    function automatic hash_t fin_pre(input hash_t h);
        hash_t t;
        t = h + (h << 3);
        return t ^ (t >> 11);
    endfunction

    // last finishing step: times 32769
    function automatic hash_t fin_post(input hash_t t);
        return t + (t << 15);
    endfunction

endpackage

// File: rtl/tmh_ram.sv
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tmh_fin.sv
module tmh_fin (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tmh_pkg::hash_t in_hash,
    output logic           out_valid,
    input  logic           out_stall,
    output tmh_pkg::hash_t hash_value
);

    logic           mid_valid_reg, mid_valid_next;
    logic           pre_valid_reg, pre_valid_next;
    logic           out_valid_reg, out_valid_next;
    tmh_pkg::hash_t mid_reg;
    tmh_pkg::hash_t pre_reg;
    tmh_pkg::hash_t out_reg;
    logic           out_load;
    logic           pre_en;
    logic           mid_en;

    // stage enables, each stage moves when the one after it has room
    assign out_load = !out_valid_reg || !out_stall;
    assign pre_en   = !pre_valid_reg || out_load;
    assign mid_en   = !mid_valid_reg || pre_en;
    assign in_ready = mid_en;

    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        pre_valid_next = pre_valid_reg;
        out_valid_next = out_valid_reg;
        if (mid_en)
        begin
            mid_valid_next = in_valid;
        end
        if (pre_en)
        begin
            pre_valid_next = mid_valid_reg;
        end
        if (out_load)
        begin
            out_valid_next = pre_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            pre_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            pre_valid_reg <= pre_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: mixed value, times 9 with xor, times 32769
    always_ff @(posedge clk)
    begin
        if (mid_en && in_valid)
        begin
            mid_reg <= in_hash;
        end
        if (pre_en && mid_valid_reg)
        begin
            pre_reg <= tmh_pkg::fin_pre(mid_reg);
        end
        if (out_load && pre_valid_reg)
        begin
            out_reg <= tmh_pkg::fin_post(pre_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

endmodule

// File: rtl/table_mapped_one_at_a_time_hash.sv
// From the edge that accepts the last byte of a string to hash_value valid: table read
//   at that edge, then mix, first finish, second finish into the output register.
// Throughput: one word per cycle, load or hash, with no idle cycles between strings,
//   except while in_stall holds input back behind a full finishing pipeline.
// Reset clears the running hash and all valid flags; translation table entries are
//   undefined until loaded and need no clearing.
module table_mapped_one_at_a_time_hash #(
    parameter int TABLE_ENTRIES = tmh_pkg::TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    logic           in_acc;
    logic           load_acc;
    logic           hash_acc;
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_last_reg;
    logic           s1_go;
    logic           s1_free;
    logic           fin_ready;
    tmh_pkg::byte_t map_byte;
    tmh_pkg::hash_t hash_reg, hash_next;
    tmh_pkg::hash_t mixed;

    // input handshake
    assign s1_go    = s1_valid_reg && (!s1_last_reg || fin_ready);
    assign s1_free  = !s1_valid_reg || s1_go;
    assign in_stall = !s1_free;
    assign in_acc   = in_valid && s1_free;
    assign load_acc = in_acc && (req_type == tmh_pkg::REQ_LOAD);
    assign hash_acc = in_acc && (req_type == tmh_pkg::REQ_HASH);

    // translation table
    tmh_ram #(
        .WIDTH (tmh_pkg::BYTE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_acc),
        .wr_addr (table_index[ADDR_W-1:0]),
        .wr_data (table_value),
        .rd_en   (hash_acc),
        .rd_addr (data_byte[ADDR_W-1:0]),
        .rd_data (map_byte)
    );

    // mix stage, running hash cleared after the last byte
    assign mixed = tmh_pkg::mix_byte(hash_reg, map_byte);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        hash_next     = hash_reg;
        if (s1_go)
        begin
            s1_valid_next = 1'b0;
            hash_next     = s1_last_reg ? '0 : mixed;
        end
        if (hash_acc)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hash_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            hash_reg     <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_acc)
        begin
            s1_last_reg <= last_byte;
        end
    end

    // finishing pipeline and output register
    tmh_fin u_fin (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg && s1_last_reg),
        .in_ready   (fin_ready),
        .in_hash    (mixed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    // a finished string leaves the running hash at zero
    a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (hash_reg == '0))
        else $error("running hash not cleared after last byte");

    // input is held back only while the mix stage is occupied
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty mix stage");

    // a waiting mix stage keeps its table byte and running hash
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(map_byte) && $stable(hash_reg)))
        else $error("mix stage operands changed while waiting");

    // a load accepted while the mix stage is empty leaves the running hash unchanged
    a_load_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (load_acc && !s1_valid_reg) |=> $stable(hash_reg))
        else $error("running hash changed by a table load");

endmodule
